@@ src/rtnh_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtnh_pkg
// shared types and constants of the ray/triangle nearest-hit core
// ----------------------------------------------------------------------------
package rtnh_pkg;

	localparam int CoordWidth = 32;
	localparam int FracBits   = 16;
	localparam int DistWidth  = 31;
	localparam int DiffWidth  = CoordWidth + 1;
	localparam int ProdWidth  = 2 * DiffWidth + 1;
	localparam int WideWidth  = 3 * DiffWidth + 4;
	localparam int AccWidth   = WideWidth + 2;
	localparam int NumWidth   = AccWidth + FracBits + 1;
	localparam int DivWidth   = NumWidth + 1;
	localparam int SplitWidth = DiffWidth + 1;
	localparam int CfgIdxWidth = 3;
	localparam int SlotWidth  = 4;

	localparam logic [DistWidth-1:0] DistMax = '1;

	localparam logic [CfgIdxWidth-1:0] RegOrgX = 3'd0;
	localparam logic [CfgIdxWidth-1:0] RegOrgY = 3'd1;
	localparam logic [CfgIdxWidth-1:0] RegOrgZ = 3'd2;
	localparam logic [CfgIdxWidth-1:0] RegDirX = 3'd3;
	localparam logic [CfgIdxWidth-1:0] RegDirY = 3'd4;
	localparam logic [CfgIdxWidth-1:0] RegDirZ = 3'd5;

	typedef struct packed {
		logic signed [CoordWidth-1:0] vertex_a_x;
		logic signed [CoordWidth-1:0] vertex_a_y;
		logic signed [CoordWidth-1:0] vertex_a_z;
		logic signed [CoordWidth-1:0] vertex_b_x;
		logic signed [CoordWidth-1:0] vertex_b_y;
		logic signed [CoordWidth-1:0] vertex_b_z;
		logic signed [CoordWidth-1:0] vertex_c_x;
		logic signed [CoordWidth-1:0] vertex_c_y;
		logic signed [CoordWidth-1:0] vertex_c_z;
		logic                         first_of_ray;
	} tri_word_t;

	typedef struct packed {
		logic                 improved;
		logic [DistWidth-1:0] nearest_distance;
		logic                 degenerate;
	} hit_word_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CROSS, ST_DET, ST_DOT, ST_SIGN, ST_TEST, ST_DIV, ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage
`default_nettype wire

@@ src/ray_triangle_nearest_hit_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit_core
// Moller-Trumbore ray/triangle test with nearest-hit tracking
// ----------------------------------------------------------------------------
// The ray is written through the register port (index 0..2 origin, 3..5
// direction, Q16.16); the user must write it only while the core is idle,
// as the core itself does not enforce this. Each triangle word arrives on
// tri_valid/tri_stall and yields one hit word on hit_valid/hit_stall.
// Products go through one shared 35x33 multiplier with an accumulator, one
// partial product a cycle: first the cross products, then each product with
// a wide factor is split into a low and a high half, for the determinant
// and the three remaining dot products, then a sign and a bound check.
// Hits that do not saturate then run a restoring divider at one quotient
// bit a cycle. A zero determinant ends the item once it is known, and
// an item without a hit skips the divider; the next triangle is taken the
// cycle after the hit word has left the output register.
// While hit_stall is high the word holds and tri_stall stays high.
// Reset clears the ray to zero and sets the nearest distance to the maximum.
// ----------------------------------------------------------------------------
module ray_triangle_nearest_hit_core import rtnh_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CfgIdxWidth-1:0] cfg_idx,
	input  wire logic [CoordWidth-1:0]  cfg_data,
	input  wire logic                   tri_valid,
	output logic                        tri_stall,
	input  wire tri_word_t              tri_word,
	output logic                        hit_valid,
	input  wire logic                   hit_stall,
	output hit_word_t                   hit_word
);
	typedef logic signed [DiffWidth-1:0] diff_t;
	typedef logic signed [AccWidth-1:0]  acc_t;
	typedef logic signed [SplitWidth:0]  mulx_t;

	logic signed [CoordWidth-1:0] org_q [3];
	logic signed [CoordWidth-1:0] dir_q [3];
	diff_t e1_q [3];
	diff_t e2_q [3];
	diff_t tv_q [3];
	acc_t  pv_q [3];
	acc_t  qv_q [3];
	acc_t  det_q, a_q, b_q, c_q, acc_q;
	logic  first_q;
	logic [DistWidth-1:0] near_q;

	state_t state_q, state_d;
	logic [SlotWidth-1:0] slot_q, slot_d;
	logic  half_q, half_d;
	logic  hv_q;
	hit_word_t out_q;

	// shared multiplier operands
	acc_t mul_w;
	logic mul_wide;
	mulx_t mul_x;
	diff_t mul_y;
	logic signed [SplitWidth+DiffWidth:0] prod;
	acc_t prod_t;

	logic div_start;
	logic [NumWidth-1:0] div_num;
	div_ctl_t div_ctl;
	logic [DistWidth-1:0] div_quo;
	logic hit_ok, sat, take;

	assign take = tri_valid && !tri_stall;
	assign tri_stall = (state_q != ST_IDLE) || hv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				org_q[i] <= '0;
				dir_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_idx)
				RegOrgX: org_q[0] <= cfg_data;
				RegOrgY: org_q[1] <= cfg_data;
				RegOrgZ: org_q[2] <= cfg_data;
				RegDirX: dir_q[0] <= cfg_data;
				RegDirY: dir_q[1] <= cfg_data;
				RegDirZ: dir_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// operand schedule: cross P=DxE2, Q=TxE1, then det, a, b, c
	always_comb begin
		mul_w    = '0;
		mul_y    = '0;
		mul_wide = 1'b0;
		case (state_q)
			ST_CROSS: begin
				case (slot_q)
					4'd0:  begin mul_w = AccWidth'(dir_q[1]); mul_y = e2_q[2]; end
					4'd1:  begin mul_w = AccWidth'(dir_q[2]); mul_y = e2_q[1]; end
					4'd2:  begin mul_w = AccWidth'(dir_q[2]); mul_y = e2_q[0]; end
					4'd3:  begin mul_w = AccWidth'(dir_q[0]); mul_y = e2_q[2]; end
					4'd4:  begin mul_w = AccWidth'(dir_q[0]); mul_y = e2_q[1]; end
					4'd5:  begin mul_w = AccWidth'(dir_q[1]); mul_y = e2_q[0]; end
					4'd6:  begin mul_w = AccWidth'(tv_q[1]); mul_y = e1_q[2]; end
					4'd7:  begin mul_w = AccWidth'(tv_q[2]); mul_y = e1_q[1]; end
					4'd8:  begin mul_w = AccWidth'(tv_q[2]); mul_y = e1_q[0]; end
					4'd9:  begin mul_w = AccWidth'(tv_q[0]); mul_y = e1_q[2]; end
					4'd10: begin mul_w = AccWidth'(tv_q[0]); mul_y = e1_q[1]; end
					default: begin mul_w = AccWidth'(tv_q[1]); mul_y = e1_q[0]; end
				endcase
			end
			ST_DET: begin
				mul_wide = 1'b1;
				mul_w = pv_q[slot_q[1:0]];
				mul_y = e1_q[slot_q[1:0]];
			end
			ST_DOT: begin
				mul_wide = 1'b1;
				case (slot_q)
					4'd0, 4'd1, 4'd2: begin
						mul_w = pv_q[slot_q[1:0]];
						mul_y = tv_q[slot_q[1:0]];
					end
					4'd3, 4'd4, 4'd5: begin
						mul_w = qv_q[2'(slot_q - 4'd3)];
						mul_y = diff_t'(dir_q[2'(slot_q - 4'd3)]);
					end
					default: begin
						mul_w = qv_q[2'(slot_q - 4'd6)];
						mul_y = e2_q[2'(slot_q - 4'd6)];
					end
				endcase
			end
			default: ;
		endcase
	end

	// wide factors of at most 67 bits go through in two halves: unsigned low
	// bits first, then the signed high part weighted by 2^SplitWidth
	assign mul_x = !mul_wide ? mulx_t'(mul_w)
		: half_q ? mulx_t'(mul_w >>> SplitWidth)
		: mulx_t'({1'b0, mul_w[SplitWidth-1:0]});
	assign prod   = mul_x * mul_y;
	assign prod_t = (mul_wide && half_q) ? (acc_t'(prod) <<< SplitWidth) : acc_t'(prod);

	assign hit_ok = !a_q[AccWidth-1] && (det_q >= a_q) && !b_q[AccWidth-1]
		&& (det_q >= a_q + b_q) && !c_q[AccWidth-1] && (c_q != '0);
	assign div_num = NumWidth'(c_q) << FracBits;
	assign sat = (div_num >> DistWidth) >= NumWidth'(det_q);

	always_comb begin
		state_d   = state_q;
		slot_d    = slot_q;
		half_d    = half_q;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: if (take) begin
				state_d = ST_CROSS;
				slot_d  = '0;
				half_d  = 1'b0;
			end
			ST_CROSS: begin
				slot_d = slot_q + 4'd1;
				if (slot_q == 4'd11) begin
					state_d = ST_DET;
					slot_d  = '0;
				end
			end
			ST_DET: begin
				half_d = !half_q;
				if (half_q) begin
					slot_d = slot_q + 4'd1;
					if (slot_q == 4'd2) begin
						slot_d  = '0;
						state_d = ST_DOT;
					end
				end
			end
			ST_DOT: begin
				half_d = !half_q;
				if (half_q) begin
					slot_d = slot_q + 4'd1;
					if (slot_q == 4'd8) state_d = ST_SIGN;
				end
				if (det_q == '0) state_d = ST_DONE;
			end
			ST_SIGN: state_d = ST_TEST;
			ST_TEST: begin
				if (hit_ok && !sat) begin
					state_d   = ST_DIV;
					div_start = 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: if (div_ctl.done) state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
			half_q  <= 1'b0;
			hv_q    <= 1'b0;
			near_q  <= DistMax;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
			half_q  <= half_d;
			if (hv_q && !hit_stall) hv_q <= 1'b0;
			if (take && tri_word.first_of_ray) near_q <= DistMax;
			if (state_q == ST_DONE) begin
				hv_q <= 1'b1;
				if (out_q.improved) near_q <= out_q.nearest_distance;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			e1_q[0] <= diff_t'(tri_word.vertex_b_x) - diff_t'(tri_word.vertex_a_x);
			e1_q[1] <= diff_t'(tri_word.vertex_b_y) - diff_t'(tri_word.vertex_a_y);
			e1_q[2] <= diff_t'(tri_word.vertex_b_z) - diff_t'(tri_word.vertex_a_z);
			e2_q[0] <= diff_t'(tri_word.vertex_c_x) - diff_t'(tri_word.vertex_a_x);
			e2_q[1] <= diff_t'(tri_word.vertex_c_y) - diff_t'(tri_word.vertex_a_y);
			e2_q[2] <= diff_t'(tri_word.vertex_c_z) - diff_t'(tri_word.vertex_a_z);
			tv_q[0] <= diff_t'(org_q[0]) - diff_t'(tri_word.vertex_a_x);
			tv_q[1] <= diff_t'(org_q[1]) - diff_t'(tri_word.vertex_a_y);
			tv_q[2] <= diff_t'(org_q[2]) - diff_t'(tri_word.vertex_a_z);
			first_q <= tri_word.first_of_ray;
			acc_q   <= '0;
			det_q   <= '0;
			out_q   <= '0;
		end
		case (state_q)
			ST_CROSS: begin
				if (!slot_q[0]) begin
					acc_q <= prod_t;
				end else begin
					if (slot_q < 4'd6) pv_q[2'(slot_q >> 1)] <= acc_q - prod_t;
					else qv_q[2'((slot_q - 4'd6) >> 1)] <= acc_q - prod_t;
				end
			end
			ST_DET: begin
				if (slot_q == 4'd2 && half_q) det_q <= acc_q + prod_t;
				else if (slot_q == 4'd0 && !half_q) acc_q <= prod_t;
				else acc_q <= acc_q + prod_t;
			end
			ST_DOT: begin
				if ((slot_q == 4'd0 || slot_q == 4'd3 || slot_q == 4'd6) && !half_q)
					acc_q <= prod_t;
				else if ((slot_q == 4'd2 || slot_q == 4'd5 || slot_q == 4'd8) && half_q) begin
					if (slot_q == 4'd2) a_q <= acc_q + prod_t;
					else if (slot_q == 4'd5) b_q <= acc_q + prod_t;
					else c_q <= acc_q + prod_t;
				end else begin
					acc_q <= acc_q + prod_t;
				end
			end
			ST_SIGN: if (det_q[AccWidth-1]) begin
				det_q <= -det_q;
				a_q   <= -a_q;
				b_q   <= -b_q;
				c_q   <= -c_q;
			end
			ST_DIV: if (div_ctl.done && div_quo != '0 && div_quo < near_q) begin
				out_q.improved <= 1'b1;
				out_q.nearest_distance <= div_quo;
			end
			ST_DONE: begin
				if (!out_q.improved) out_q.nearest_distance <= near_q;
				out_q.degenerate <= (det_q == '0);
			end
			default: ;
		endcase
	end

	rtnh_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (det_q),
		.ctl   (div_ctl),
		.quo   (div_quo)
	);

	assign hit_valid = hv_q;
	assign hit_word  = out_q;

	as_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> tri_stall) else $error("triangle taken while busy");
	as_word_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> !hv_q) else $error("hit word overwritten");
	as_near_never_grows: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == ST_DONE) && !$past(first_q) |-> near_q <= $past(near_q))
		else $error("nearest distance grew");
	as_improved_word: assert property (@(posedge clk) disable iff (!arst_n)
		hv_q && out_q.improved |-> !out_q.degenerate && out_q.nearest_distance != DistMax)
		else $error("improved word inconsistent");
endmodule
`default_nettype wire

@@ src/rtnh_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtnh_div
// restoring divider: one quotient bit a cycle, distance quotient of 31 bits
// ----------------------------------------------------------------------------
module rtnh_div import rtnh_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [NumWidth-1:0]  num,
	input  wire logic [AccWidth-1:0]  den,
	output div_ctl_t                  ctl,
	output logic     [DistWidth-1:0]  quo
);
	logic [DivWidth-1:0]  rem_q;
	logic [DivWidth-1:0]  den_q;
	logic [DistWidth-1:0] quo_q;
	logic [4:0]           bit_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DivWidth-1:0]  trial;
	logic                 fits;

	// compare on the shifted remainder so an overflow of the shifted divisor never reaches the compare
	always_comb begin
		trial = den_q << bit_q;
		fits  = (rem_q >> bit_q) >= den_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= 5'(DistWidth - 1);
			end else if (busy_q) begin
				if (bit_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					bit_q <= bit_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DivWidth'(num);
			den_q <= DivWidth'(den);
			quo_q <= '0;
		end else if (busy_q && fits) begin
			rem_q        <= rem_q - trial;
			quo_q[bit_q] <= 1'b1;
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;
	assign quo       = quo_q;

	as_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without work");
	as_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider busy and done together");
	as_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");
endmodule
`default_nettype wire

@@ verif/tb_ray_triangle_nearest_hit_core.sv @@
// ----------------------------------------------------------------------------
// tb_ray_triangle_nearest_hit_core
// self-checking bench for the ray/triangle nearest-hit core
// ----------------------------------------------------------------------------
// Rays are loaded through the register port while the core is idle. Triangle
// words are sent with random gaps and hit words are taken with random stalls
// while idle_on is set. An exact wide-integer model of the intersection
// test predicts each hit word, compared field by field. Most triangles are
// built around a point on the ray so that hits and nearer hits happen often.
// ----------------------------------------------------------------------------
module tb_ray_triangle_nearest_hit_core;
	import rtnh_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [255:0] wide_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CfgIdxWidth-1:0] cfg_idx = '0;
	logic [CoordWidth-1:0]  cfg_data = '0;
	logic                   tri_valid = 1'b0;
	logic                   tri_stall;
	tri_word_t              tri_word = '0;
	logic                   hit_valid;
	logic                   hit_stall = 1'b0;
	hit_word_t              hit_word;

	ray_triangle_nearest_hit_core uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .tri_valid(tri_valid), .tri_stall(tri_stall),
		.tri_word(tri_word), .hit_valid(hit_valid), .hit_stall(hit_stall),
		.hit_word(hit_word)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic signed [CoordWidth-1:0] ray [6];
	logic [DistWidth-1:0]         nearest_kept = DistMax;
	hit_word_t                    hit_expected [$];
	logic                         idle_on = 1'b0;
	int                           errors = 0;
	int                           words_sent = 0;
	int                           hits_seen = 0;
	int                           degen_seen = 0;

	// exact Moller-Trumbore test, updates the kept distance
	function automatic hit_word_t nearest_after(tri_word_t w);
		wide_t va [3], vb [3], vc [3];
		wide_t e1 [3], e2 [3], tv [3], dv [3], p [3], q [3];
		wide_t det, a, b, c, num;
		logic [DistWidth-1:0] dist_val;
		hit_word_t r;
		va[0] = $signed(w.vertex_a_x); va[1] = $signed(w.vertex_a_y);
		va[2] = $signed(w.vertex_a_z);
		vb[0] = $signed(w.vertex_b_x); vb[1] = $signed(w.vertex_b_y);
		vb[2] = $signed(w.vertex_b_z);
		vc[0] = $signed(w.vertex_c_x); vc[1] = $signed(w.vertex_c_y);
		vc[2] = $signed(w.vertex_c_z);
		r = '0;
		if (w.first_of_ray)
			nearest_kept = DistMax;
		for (int i = 0; i < 3; i++) begin
			e1[i] = vb[i] - va[i];
			e2[i] = vc[i] - va[i];
			tv[i] = wide_t'($signed(ray[i])) - va[i];
			dv[i] = $signed(ray[3 + i]);
		end
		p[0] = dv[1] * e2[2] - dv[2] * e2[1];
		p[1] = dv[2] * e2[0] - dv[0] * e2[2];
		p[2] = dv[0] * e2[1] - dv[1] * e2[0];
		q[0] = tv[1] * e1[2] - tv[2] * e1[1];
		q[1] = tv[2] * e1[0] - tv[0] * e1[2];
		q[2] = tv[0] * e1[1] - tv[1] * e1[0];
		det = p[0] * e1[0] + p[1] * e1[1] + p[2] * e1[2];
		if (det == 0) begin
			r.degenerate = 1'b1;
		end else begin
			a = p[0] * tv[0] + p[1] * tv[1] + p[2] * tv[2];
			b = q[0] * dv[0] + q[1] * dv[1] + q[2] * dv[2];
			c = q[0] * e2[0] + q[1] * e2[1] + q[2] * e2[2];
			if (det < 0) begin
				det = -det; a = -a; b = -b; c = -c;
			end
			if (a >= 0 && a <= det && b >= 0 && a + b <= det && c > 0) begin
				num = c <<< FracBits;
				if (num >= (det <<< 31))
					dist_val = DistMax;
				else
					dist_val = DistWidth'(num / det);
				if (dist_val != 0 && dist_val < nearest_kept) begin
					nearest_kept = dist_val;
					r.improved = 1'b1;
				end
			end
		end
		r.nearest_distance = nearest_kept;
		return r;
	endfunction

	task automatic load_ray(input logic signed [CoordWidth-1:0] v [6]);
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= CfgIdxWidth'(i);
			cfg_data <= v[i];
			ray[i] = v[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic send_triangle(input tri_word_t w);
		int gap;
		logic taken;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			tri_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tri_valid <= 1'b1;
		tri_word <= w;
		do begin
			@(negedge clk);
			taken = !tri_stall;
			@(posedge clk);
		end while (!taken);
		hit_expected.push_back(nearest_after(w));
		words_sent++;
	endtask

	task automatic drain;
		tri_valid <= 1'b0;
		while (hit_expected.size() != 0)
			@(posedge clk);
		// every hit word is out, so the core is idle before the next ray is loaded
		repeat (80) @(posedge clk);
	endtask

	function automatic logic signed [CoordWidth-1:0] rand_coord(int bits);
		logic signed [CoordWidth-1:0] v;
		v = $urandom;
		return v >>> (CoordWidth - bits);
	endfunction

	// triangle whose centroid lies on the ray at a random distance
	function automatic tri_word_t triangle_on_ray(int span);
		logic signed [CoordWidth-1:0] pt [3], d1 [3], d2 [3];
		longint s;
		tri_word_t w;
		s = $urandom_range(1, 1 << 20);
		for (int i = 0; i < 3; i++) begin
			pt[i] = ray[i] + CoordWidth'((longint'(ray[3 + i]) * s) >>> FracBits);
			d1[i] = rand_coord(span);
			d2[i] = rand_coord(span);
		end
		w.vertex_a_x = pt[0] + d1[0]; w.vertex_a_y = pt[1] + d1[1];
		w.vertex_a_z = pt[2] + d1[2];
		w.vertex_b_x = pt[0] + d2[0]; w.vertex_b_y = pt[1] + d2[1];
		w.vertex_b_z = pt[2] + d2[2];
		w.vertex_c_x = pt[0] - d1[0] - d2[0]; w.vertex_c_y = pt[1] - d1[1] - d2[1];
		w.vertex_c_z = pt[2] - d1[2] - d2[2];
		w.first_of_ray = ($urandom_range(0, 7) == 0);
		return w;
	endfunction

	function automatic tri_word_t noise_triangle();
		tri_word_t w;
		w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, 1'($urandom)};
		return w;
	endfunction

	task automatic test_zero_ray;
		tri_word_t w;
		for (int i = 0; i < 3; i++) begin
			w = noise_triangle();
			send_triangle(w);
		end
		drain();
	endtask

	task automatic test_directed;
		logic signed [CoordWidth-1:0] v [6];
		tri_word_t w;
		v = '{0, 0, 0, 0, 0, 32'sh0001_0000};
		load_ray(v);
		@(posedge clk);
		// stray register indexes must be ignored
		cfg_we <= 1'b1; cfg_idx <= 3'd6; cfg_data <= 32'hDEAD_BEEF;
		@(posedge clk);
		cfg_idx <= 3'd7; cfg_data <= 32'h1234_5678;
		@(posedge clk);
		cfg_we <= 1'b0;
		// unit triangle at z = 5, then nearer at z = 2, then reversed winding at z = 1 and z = 3
		w = '{-32'sh10000, -32'sh10000, 32'sh50000, 32'sh10000, -32'sh10000, 32'sh50000,
			0, 32'sh10000, 32'sh50000, 1'b1};
		send_triangle(w);
		w.vertex_a_z = 32'sh20000; w.vertex_b_z = 32'sh20000; w.vertex_c_z = 32'sh20000;
		w.first_of_ray = 1'b0;
		send_triangle(w);
		w = '{0, 32'sh10000, 32'sh10000, 32'sh10000, -32'sh10000, 32'sh10000,
			-32'sh10000, -32'sh10000, 32'sh10000, 1'b0};
		send_triangle(w);
		w.vertex_a_z = 32'sh30000; w.vertex_b_z = 32'sh30000; w.vertex_c_z = 32'sh30000;
		send_triangle(w);
		// hit behind the origin
		w.vertex_a_z = -32'sh30000; w.vertex_b_z = -32'sh30000;
		w.vertex_c_z = -32'sh30000; w.first_of_ray = 1'b1;
		send_triangle(w);
		// triangle through the origin, distance zero
		w.vertex_a_z = 32'sh0; w.vertex_b_z = 32'sh0; w.vertex_c_z = 32'sh0;
		send_triangle(w);
		// huge distance, just below the saturation bound
		w.vertex_a_z = 32'sh7FFF_FFFF; w.vertex_b_z = 32'sh7FFF_FFFF;
		w.vertex_c_z = 32'sh7FFF_FFFF;
		send_triangle(w);
		// edge and vertex on the ray
		w = '{0, 0, 32'sh40000, 32'sh10000, 0, 32'sh40000, 0, 32'sh10000, 32'sh40000, 1'b0};
		send_triangle(w);
		w = '{-32'sh10000, 0, 32'sh38000, 32'sh10000, 0, 32'sh38000,
			0, 32'sh10000, 32'sh38000, 1'b0};
		send_triangle(w);
		// degenerate: collapsed triangle, then plane parallel to the ray
		w = '{32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000,
			0, 0, 0, 1'b0};
		send_triangle(w);
		w = '{0, 0, 0, 32'sh10000, 0, 0, 32'sh10000, 0, 32'sh10000, 1'b0};
		send_triangle(w);
		// extreme coordinates
		w = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 1'b1};
		send_triangle(w);
		w = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh8000_0000, 1'b0};
		send_triangle(w);
		drain();
		// extreme ray settings
		v = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
		load_ray(v);
		for (int i = 0; i < 4; i++) begin
			w = noise_triangle();
			send_triangle(w);
		end
		w = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh8000_0000, 1'b1};
		send_triangle(w);
		drain();
	endtask

	task automatic test_random_rays(input int n_rays, input int per_ray);
		logic signed [CoordWidth-1:0] v [6];
		tri_word_t w;
		int span;
		for (int r = 0; r < n_rays; r++) begin
			for (int i = 0; i < 6; i++)
				v[i] = rand_coord(i < 3 ? 24 : 18);
			if (r == 0)
				v = '{0, 0, 0, 0, 0, -32'sh0001_0000};
			load_ray(v);
			idle_on = (r % 3 != 2);
			span = $urandom_range(6, 20);
			for (int k = 0; k < per_ray; k++) begin
				case ($urandom_range(0, 9))
					0: w = noise_triangle();
					1: begin
						w = triangle_on_ray(span);
						w.vertex_b_x = w.vertex_a_x; w.vertex_b_y = w.vertex_a_y;
						w.vertex_b_z = w.vertex_a_z;
					end
					2: begin
						w = triangle_on_ray(span);
						w.vertex_c_x = w.vertex_c_x ^ 32'($urandom);
					end
					default: w = triangle_on_ray(span);
				endcase
				send_triangle(w);
			end
			drain();
		end
	endtask

	// hit words are taken on the rising edge after being seen at the falling one
	logic hit_take = 1'b0;
	int   stall_left = 0;

	always @(negedge clk) begin
		hit_take = arst_n && hit_valid && !hit_stall;
		if (hit_take) begin
			if (hit_expected.size() == 0) begin
				$display("%0t: unexpected hit word %p", $time, hit_word);
				errors++;
			end else begin
				hit_word_t e;
				e = hit_expected.pop_front();
				if (hit_word.improved !== e.improved) begin
					$display("%0t: improved expected %0b got %0b", $time, e.improved,
						hit_word.improved);
					errors++;
				end
				if (hit_word.nearest_distance !== e.nearest_distance) begin
					$display("%0t: nearest_distance expected %h got %h", $time,
						e.nearest_distance, hit_word.nearest_distance);
					errors++;
				end
				if (hit_word.degenerate !== e.degenerate) begin
					$display("%0t: degenerate expected %0b got %0b", $time, e.degenerate,
						hit_word.degenerate);
					errors++;
				end
				hits_seen += e.improved;
				degen_seen += e.degenerate;
			end
		end
	end

	always @(posedge clk) begin
		if (hit_take) begin
			stall_left <= idle_on ? $urandom_range(0, 3) : 0;
			hit_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			hit_stall <= 1'b1;
		end else begin
			hit_stall <= 1'b0;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < 6; i++)
			ray[i] = '0;
		test_zero_ray();
		idle_on = 1'b1;
		test_directed();
		test_random_rays(7, 240);
		$display("sent %0d triangle words over several rays: %0d nearer hits, %0d degenerate",
			words_sent, hits_seen, degen_seen);
		if (errors == 0 && hit_expected.size() == 0)
			$display("ray_triangle_nearest_hit_core test passed");
		else
			$display("ray_triangle_nearest_hit_core test failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("ray_triangle_nearest_hit_core test failed");
		$finish;
	end

endmodule
